/* rtl/core/bsle_pkg.sv */
// Package for the bounded sorted list engine: field widths, action and
// status codes, and the request/response transaction structs.
// No dependencies.
`default_nettype none

package bsle_pkg;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_INS_HEAD   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INS_SORTED = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INS_TAIL   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REM_HEAD   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REM_TAIL   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REM_KEY    = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]     action;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] removed_key;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/bounded_sorted_list_engine.sv */
// Bounded sorted list engine: ordered key store in a RAM with a small
// sequencer around one shared key comparator.
// Depends on bsle_pkg and bsle_ram.
//
//  Channel   Ports                  Handshake
//  --------  ---------------------  ----------------------------------------
//  request   start, busy, req_data  taken at an edge with start=1, busy=0
//  response  rsp_strobe, rsp_data   valid for exactly one cycle, no backpressure
//
// Sequencing: every search compare and every move of one entry is a read
//   state and a compare or write state (SCAN_RD/SCAN_CK, UP_RD/UP_WR,
//   DN_RD/DN_WR); head or tail removal reads its entry the same way
//   (TAKE_RD/TAKE_CK). Each entry goes through the single RAM read port with
//   its registered data. A dropped insert, an empty list or an unused code
//   goes straight to DONE. The longest transaction is a sorted insert that
//   lands ahead of the tail of a list holding DEPTH-1 entries.
// Reset: synchronous; clears the count and the sequencer. The key RAM is
//   not cleared; only entries below the count are ever used.
// Stalls: busy stays high until the response strobe; the response cannot
//   be held off, and a new request may be taken in the strobe cycle.
`default_nettype none

module bounded_sorted_list_engine
   import bsle_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);       // RAM address width
   localparam int CW = $clog2(DEPTH + 1);   // count width, holds DEPTH

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,   // issue read of entry idx during a search
      S_SCAN_CK,   // compare entry idx against the key
      S_UP_RD,     // read entry idx-1 to move it up
      S_UP_WR,     // write it to idx
      S_PLACE,     // write new key at pos
      S_TAKE_RD,   // read entry pos for head/tail removal
      S_TAKE_CK,   // capture removed key
      S_DN_RD,     // read entry idx+1 to move it down
      S_DN_WR,     // write it to idx
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]             occ_ff, occ_in;
   logic [CW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic [ACTION_W-1:0]       act_ff, act_in;
   logic signed [KEY_W-1:0]   key_ff, key_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic signed [KEY_W-1:0]   removed_ff, removed_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   // RAM port signals
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [KEY_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [KEY_W-1:0] ram_rdata;

   // shared compare unit: stored entry against the transaction key
   logic key_lt;
   logic key_eq;
   assign key_lt = $signed(ram_rdata) < key_ff;
   assign key_eq = ram_rdata == key_ff;

   logic          full;
   logic          empty;
   logic [CW-1:0] occ_dec;
   logic [CW-1:0] idx_inc;
   logic [CW-1:0] idx_dec;
   logic [CW+COUNT_W-1:0] count_wide;

   assign full       = occ_ff == CW'(DEPTH);
   assign empty      = occ_ff == '0;
   assign occ_dec    = occ_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign count_wide = {{COUNT_W{1'b0}}, occ_ff};

   bsle_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // RAM addressing per sequencer step
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_SCAN_RD: ram_raddr = idx_ff[AW-1:0];
         S_TAKE_RD: ram_raddr = pos_ff;
         S_UP_RD:   ram_raddr = idx_dec[AW-1:0];
         S_DN_RD:   ram_raddr = idx_inc[AW-1:0];
         S_UP_WR,
         S_DN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
         end
         S_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = key_ff;
         end
         default: ram_we = 1'b0;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in     = req_data.action;
               key_in     = req_data.key;
               status_in  = ST_OK;
               removed_in = '0;
               idx_in     = '0;
               state_in   = S_DONE;
               case (req_data.action)
                  ACT_INS_HEAD,
                  ACT_INS_SORTED,
                  ACT_INS_TAIL: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (req_data.action == ACT_INS_HEAD) begin
                        pos_in   = '0;
                        idx_in   = occ_ff;
                        state_in = S_UP_RD;
                     end else if (req_data.action == ACT_INS_TAIL) begin
                        pos_in   = occ_ff[AW-1:0];
                        state_in = S_PLACE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  ACT_REM_HEAD,
                  ACT_REM_TAIL: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        pos_in   = (req_data.action == ACT_REM_HEAD) ? '0
                                                                     : occ_dec[AW-1:0];
                        state_in = S_TAKE_RD;
                     end
                  end
                  ACT_REM_KEY: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: state_in = S_DONE;   // unused codes: no change
               endcase
            end
         end

         S_SCAN_RD: begin
            if (idx_ff == occ_ff) begin
               // ran off the end of the list
               if (act_ff == ACT_INS_SORTED) begin
                  pos_in   = idx_ff[AW-1:0];
                  state_in = S_PLACE;
               end else begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_DONE;
               end
            end else begin
               state_in = S_SCAN_CK;
            end
         end

         S_SCAN_CK: begin
            if (act_ff == ACT_INS_SORTED) begin
               if (key_lt) begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end else begin
                  pos_in   = idx_ff[AW-1:0];
                  idx_in   = occ_ff;
                  state_in = S_UP_RD;
               end
            end else begin
               if (key_eq) begin
                  removed_in = ram_rdata;
                  state_in   = S_DN_RD;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_SCAN_RD;
               end
            end
         end

         S_UP_RD: begin
            state_in = (idx_ff == CW'(pos_ff)) ? S_PLACE : S_UP_WR;
         end

         S_UP_WR: begin
            idx_in   = idx_dec;
            state_in = S_UP_RD;
         end

         S_PLACE: begin
            occ_in   = occ_ff + CW'(1);
            state_in = S_DONE;
         end

         S_TAKE_RD: state_in = S_TAKE_CK;

         S_TAKE_CK: begin
            removed_in = ram_rdata;
            idx_in     = CW'(pos_ff);
            state_in   = S_DN_RD;
         end

         S_DN_RD: begin
            if (idx_ff == occ_dec) begin
               occ_in   = occ_dec;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_WR;
            end
         end

         S_DN_WR: begin
            idx_in   = idx_inc;
            state_in = S_DN_RD;
         end

         S_DONE: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.removed_key = removed_ff;
            rsp_in.entry_count = count_wide[COUNT_W-1:0];
            state_in           = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      act_ff     <= act_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("entry count above DEPTH");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_FULL) |-> occ_ff == CW'(DEPTH))
      else $error("full status with room left");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_EMPTY) |-> occ_ff == '0)
      else $error("empty status with entries held");

endmodule

`default_nettype wire

/* rtl/core/bsle_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module bsle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
